### design/linear_interp_resampler_assert.svh
// assertion macros shared by the checker
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define LIRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lirs check failed");

// next-cycle implication
`define LIRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lirs check failed");

`endif

### design/lirs_pkg.sv
package lirs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // phase step register
  localparam int unsigned STEP_W = 23;
  localparam logic [STEP_W-1:0] STEP_RESET = 23'd65536;

  // results per input sample are capped
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_OUT,
    ST_END
  } lirs_state_e;

  typedef struct packed {
    logic mul_en;
    logic out_load;
  } lirs_ctrl_t;

endpackage

### design/linear_interp_resampler.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_sample_i, block_last_i
// out       output     out_valid_o / out_stall_i  out_sample_o, run_last_o, block_end_o
// cfg       input      cfg_we_i                   cfg_data_i (phase step, Q fraction)
//
// an input sample with n results takes an accept step, then
// multiply, add and present for each result, then a phase wrap
// step; the single shared multiplier serves every result in turn
// a sample whose phase is already at or past one skips to the phase wrap, no result
// an output stall holds the block in the present step; reset clears state,
// the previous sample and the phase, and sets the step to one
module linear_interp_resampler #(
  parameter int unsigned SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic        [lirs_pkg::STEP_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_i,
  input  logic                              block_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_o,
  output logic                              run_last_o,
  output logic                              block_end_o
);
  import lirs_pkg::*;

  localparam int unsigned PHASE_W = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
  localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

  lirs_state_e state_q, state_d;
  lirs_ctrl_t  ctrl;

  logic [STEP_W-1:0]  step_q;
  logic [PHASE_W-1:0] phase_q;
  logic [PHASE_W-1:0] phase_sum;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [SAMPLE_BITS-1:0] cur_q;
  logic mark_q;
  logic [CNT_W-1:0] cnt_q;
  logic out_valid_q;
  logic run_last_q;
  logic block_end_q;
  logic in_take;
  logic out_take;
  logic phase_ge_one;
  logic run_done;

  assign in_take      = in_valid_i && (state_q == ST_IDLE);
  assign out_take     = out_valid_q && !out_stall_i;
  assign phase_ge_one = |phase_q[PHASE_W-1:FRAC_BITS];
  assign phase_sum    = phase_q + PHASE_W'(step_q);
  assign run_done     = (|phase_sum[PHASE_W-1:FRAC_BITS]) || (cnt_q == CNT_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = phase_ge_one ? ST_END : ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_OUT;
      ST_OUT: begin
        if (out_take) begin
          state_d = run_last_q ? ST_END : ST_MUL;
        end
      end
      ST_END:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl.mul_en   = (state_q == ST_MUL);
    ctrl.out_load = (state_q == ST_ADD);
    in_stall_o    = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_RESET;
      phase_q     <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      run_last_q  <= 1'b0;
      block_end_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      if (in_take) begin
        cnt_q <= '0;
      end
      if (state_q == ST_ADD) begin
        phase_q     <= phase_sum;
        cnt_q       <= cnt_q + CNT_W'(1);
        out_valid_q <= 1'b1;
        run_last_q  <= run_done;
        block_end_q <= run_done && mark_q;
      end
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_END) begin
        // a capped run can leave the phase below one
        phase_q <= phase_ge_one ? (phase_q - ONE_PHASE) : '0;
        prev_q  <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cur_q  <= in_sample_i;
      mark_q <= block_last_i;
    end
  end

  lirs_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .prev_i  (prev_q),
    .cur_i   (cur_q),
    .frac_i  (phase_q[FRAC_BITS-1:0]),
    .sample_o(out_sample_o)
  );

  assign out_valid_o = out_valid_q;
  assign run_last_o  = run_last_q;
  assign block_end_o = block_end_q;

endmodule

### design/lirs_interp.sv
module lirs_interp #(
  parameter int unsigned SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  lirs_pkg::lirs_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  input  logic signed [SAMPLE_BITS-1:0] cur_i,
  input  logic        [FRAC_BITS-1:0]   frac_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  import lirs_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned ACC_W  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // prev + (cur - prev) * frac, all scaled by one phase unit
  assign diff = $signed({cur_i[SAMPLE_BITS-1], cur_i}) - $signed({prev_i[SAMPLE_BITS-1], prev_i});
  assign base = $signed({{2{prev_i[SAMPLE_BITS-1]}}, prev_i, {FRAC_BITS{1'b0}}});
  assign acc  = base + prod_q + HALF;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ACC_W'(diff) * ACC_W'($signed({1'b0, frac_i}));
    end
    if (ctrl_i.out_load) begin
      // floor after the half bias gives round to nearest, ties upward
      sample_q <= acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
    end
  end

  assign sample_o = sample_q;

endmodule

### design/lirs_checker.sv
`include "linear_interp_resampler_assert.svh"

module lirs_checker #(
  parameter int unsigned SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic        [lirs_pkg::STEP_W-1:0] cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic signed [SAMPLE_BITS-1:0]     in_sample_i,
  input logic                              block_last_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [SAMPLE_BITS-1:0]     out_sample_o,
  input logic                              run_last_o,
  input logic                              block_end_o
);
  import lirs_pkg::*;

  // a held result keeps its payload
  `LIRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_sample_o) && $stable(run_last_o) && $stable(block_end_o))

  // a new input transaction never overlaps a pending result
  `LIRS_ASSERT_NOW(a_in_no_pending, in_valid_i && !in_stall_o, !out_valid_o)

  // busy right after taking a sample
  `LIRS_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)

  // the block stays busy until the run ends
  `LIRS_ASSERT_NEXT(a_busy_mid_run, out_valid_o && !out_stall_i && !run_last_o, in_stall_o)

  // the block mark only rides on the final result
  `LIRS_ASSERT_NOW(a_end_on_last, out_valid_o && block_end_o, run_last_o)

endmodule

bind linear_interp_resampler lirs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lirs_checker (.*);
